// ----- src/rau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, widths, sequencer states, divider response.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int RAU_WIDTH = 32;  // signed width the reduced result must fit
    localparam int FW        = 32;  // input field width
    localparam int MW        = 64;  // intermediate magnitude width
    localparam int CW        = 7;   // divider step counter width

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WT,
        S_QA,
        S_QA_WT,
        S_QB,
        S_QB_WT,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_RN,
        S_RN_WT,
        S_RD,
        S_RD_WT,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic          done;
        logic [MW-1:0] quo;
        logic [MW-1:0] rem;
    } div_rsp_t;

endpackage

// ----- src/rau_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div: unsigned restoring divider
// One quotient bit per cycle; done pulses when quotient and remainder hold.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rau_pkg::MW-1:0]   dividend,
    input  logic [rau_pkg::MW-1:0]   divisor,
    output rau_pkg::div_rsp_t        rsp
);

    logic [rau_pkg::MW-1:0] rem_reg, rem_next;
    logic [rau_pkg::MW-1:0] quo_reg, quo_next;
    logic [rau_pkg::MW-1:0] dvs_reg, dvs_next;
    logic [rau_pkg::CW-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [rau_pkg::MW:0]   trial;
    logic [rau_pkg::MW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[rau_pkg::MW-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[rau_pkg::MW])
            begin
                rem_next = diff[rau_pkg::MW-1:0];
                quo_next = {quo_reg[rau_pkg::MW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rau_pkg::MW-1:0];
                quo_next = {quo_reg[rau_pkg::MW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rau_pkg::CW'(rau_pkg::MW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- src/rational_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: exact add/sub/mul/div of two signed fractions
// Results are reduced by Euclid gcd, sign on the numerator.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer carries op and two fractions
//   num_a/den_a, num_b/den_b. Output stream (m_*): one transfer per input
//   with the reduced num_out/den_out and a status code (ok, zero
//   denominator, overflow; on error both result fields are zero).
//   One item is in flight at a time: s_tready is high only while idle.
//   Flow: every division runs on one shared 64-bit restoring divider.
//   Add/sub: gcd of the denominators (k1 divider calls), two divides
//   by it, multiply states MUL0 to MUL3, then gcd of the result (k2
//   calls) and two divides. Mul/div skip the first gcd and its two
//   divides. A zero numerator skips the final reduction; a zero
//   denominator result is valid in the cycle after the input transfer.
//   Reset: sequencer returns to idle, output valid drops.
//   Stall: the result stays on m_tdata until m_tready is seen; no new
//   input is taken meanwhile.
// ----------------------------------------------------------------------------
module rational_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] op, [33:2] num_a, [65:34] den_a, [97:66] num_b, [129:98] den_b
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] num_out, [62:32] den_out, [64:63] status
    output logic [71:0]  m_tdata
);

    localparam int FW = rau_pkg::FW;
    localparam int MW = rau_pkg::MW;

    rau_pkg::state_t state_reg, state_next;

    logic [1:0]    op_reg, op_next;
    logic [FW-1:0] na_reg, na_next, da_reg, da_next;
    logic [FW-1:0] nb_reg, nb_next, db_reg, db_next;
    logic [FW-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic          sa_reg, sa_next, sb_reg, sb_next, sr_reg, sr_next;
    logic          pass2_reg, pass2_next;
    logic [MW-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [MW-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic [MW-1:0] n_reg, n_next, d_reg, d_next;
    logic [MW-1:0] prod_reg;
    logic [31:0]   onum_reg, onum_next;
    logic [30:0]   oden_reg, oden_next;
    logic [1:0]    ost_reg, ost_next;

    logic [FW-1:0] mul_a, mul_b;
    logic          div_start;
    logic [MW-1:0] div_dvd, div_dvs;
    rau_pkg::div_rsp_t div_rsp;

    // field decode
    logic [1:0]    in_op;
    logic [FW-1:0] in_na, in_da, in_nb, in_db;
    logic [FW-1:0] mag_na, mag_da, mag_nb, mag_db;
    logic [MW-1:0] lim;

    assign in_op  = s_tdata[1:0];
    assign in_na  = s_tdata[33:2];
    assign in_da  = s_tdata[65:34];
    assign in_nb  = s_tdata[97:66];
    assign in_db  = s_tdata[129:98];
    assign mag_na = in_na[FW-1] ? (~in_na + 1'b1) : in_na;
    assign mag_da = in_da[FW-1] ? (~in_da + 1'b1) : in_da;
    assign mag_nb = in_nb[FW-1] ? (~in_nb + 1'b1) : in_nb;
    assign mag_db = in_db[FW-1] ? (~in_db + 1'b1) : in_db;
    assign lim    = MW'(1) << (rau_pkg::RAU_WIDTH - 1);

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .rsp      (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (mag_da == '0 || mag_db == '0 ||
                        (in_op == rau_pkg::OP_DIV && mag_nb == '0))
                        state_next = rau_pkg::S_OUT;
                    else if (in_op == rau_pkg::OP_ADD || in_op == rau_pkg::OP_SUB)
                        state_next = rau_pkg::S_GCD;
                    else
                        state_next = rau_pkg::S_MUL0;
                end
            end
            rau_pkg::S_GCD:
            begin
                if (gb_reg != '0)
                    state_next = rau_pkg::S_GCD_WT;
                else if (pass2_reg)
                    state_next = rau_pkg::S_RN;
                else
                    state_next = rau_pkg::S_QA;
            end
            rau_pkg::S_GCD_WT: if (div_rsp.done) state_next = rau_pkg::S_GCD;
            rau_pkg::S_QA:     state_next = rau_pkg::S_QA_WT;
            rau_pkg::S_QA_WT:  if (div_rsp.done) state_next = rau_pkg::S_QB;
            rau_pkg::S_QB:     state_next = rau_pkg::S_QB_WT;
            rau_pkg::S_QB_WT:  if (div_rsp.done) state_next = rau_pkg::S_MUL0;
            rau_pkg::S_MUL0:   state_next = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:   state_next = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:   state_next = rau_pkg::S_MUL3;
            rau_pkg::S_MUL3:   state_next = rau_pkg::S_COMB;
            rau_pkg::S_COMB:
            begin
                if (n_next == '0)
                    state_next = rau_pkg::S_CHECK;
                else
                    state_next = rau_pkg::S_GCD;
            end
            rau_pkg::S_RN:     state_next = rau_pkg::S_RN_WT;
            rau_pkg::S_RN_WT:  if (div_rsp.done) state_next = rau_pkg::S_RD;
            rau_pkg::S_RD:     state_next = rau_pkg::S_RD_WT;
            rau_pkg::S_RD_WT:  if (div_rsp.done) state_next = rau_pkg::S_CHECK;
            rau_pkg::S_CHECK:  state_next = rau_pkg::S_OUT;
            rau_pkg::S_OUT:    if (m_tready) state_next = rau_pkg::S_IDLE;
            default:           state_next = rau_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next    = op_reg;
        na_next    = na_reg;
        da_next    = da_reg;
        nb_next    = nb_reg;
        db_next    = db_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sr_next    = sr_reg;
        pass2_next = pass2_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        onum_next  = onum_reg;
        oden_next  = oden_reg;
        ost_next   = ost_reg;
        mul_a      = na_reg;
        mul_b      = qb_reg;
        div_start  = 1'b0;
        div_dvd    = ga_reg;
        div_dvs    = gb_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                s_tready   = 1'b1;
                op_next    = in_op;
                na_next    = mag_na;
                da_next    = mag_da;
                nb_next    = mag_nb;
                db_next    = mag_db;
                sa_next    = in_na[FW-1] ^ in_da[FW-1];
                sb_next    = in_nb[FW-1] ^ in_db[FW-1] ^ (in_op == rau_pkg::OP_SUB);
                ga_next    = MW'(mag_da);
                gb_next    = MW'(mag_db);
                pass2_next = 1'b0;
                onum_next  = '0;
                oden_next  = '0;
                ost_next   = rau_pkg::ST_ZERO_DEN;
            end
            rau_pkg::S_GCD:
            begin
                div_start = (gb_reg != '0);
            end
            rau_pkg::S_GCD_WT:
            begin
                if (div_rsp.done)
                begin
                    ga_next = gb_reg;
                    gb_next = div_rsp.rem;
                end
            end
            rau_pkg::S_QA:
            begin
                div_start = 1'b1;
                div_dvd   = MW'(da_reg);
                div_dvs   = ga_reg;
            end
            rau_pkg::S_QA_WT:
            begin
                if (div_rsp.done)
                    qa_next = div_rsp.quo[FW-1:0];
            end
            rau_pkg::S_QB:
            begin
                div_start = 1'b1;
                div_dvd   = MW'(db_reg);
                div_dvs   = ga_reg;
            end
            rau_pkg::S_QB_WT:
            begin
                if (div_rsp.done)
                    qb_next = div_rsp.quo[FW-1:0];
            end
            rau_pkg::S_MUL0:
            begin
                mul_a = na_reg;
                case (op_reg)
                    rau_pkg::OP_MUL: mul_b = nb_reg;
                    rau_pkg::OP_DIV: mul_b = db_reg;
                    default:         mul_b = qb_reg;
                endcase
            end
            rau_pkg::S_MUL1:
            begin
                ta_next = prod_reg;
                case (op_reg)
                    rau_pkg::OP_MUL:
                    begin
                        mul_a = da_reg;
                        mul_b = db_reg;
                    end
                    rau_pkg::OP_DIV:
                    begin
                        mul_a = da_reg;
                        mul_b = nb_reg;
                    end
                    default:
                    begin
                        mul_a = nb_reg;
                        mul_b = qa_reg;
                    end
                endcase
            end
            rau_pkg::S_MUL2:
            begin
                tb_next = prod_reg;
                mul_a   = qa_reg;
                mul_b   = db_reg;
            end
            rau_pkg::S_MUL3:
            begin
                d_next = prod_reg;
            end
            rau_pkg::S_COMB:
            begin
                if (op_reg == rau_pkg::OP_MUL || op_reg == rau_pkg::OP_DIV)
                begin
                    n_next  = ta_reg;
                    d_next  = tb_reg;
                    sr_next = sa_reg ^ sb_reg;
                end
                else if (sa_reg == sb_reg)
                begin
                    n_next  = ta_reg + tb_reg;
                    sr_next = sa_reg;
                end
                else if (ta_reg >= tb_reg)
                begin
                    n_next  = ta_reg - tb_reg;
                    sr_next = sa_reg;
                end
                else
                begin
                    n_next  = tb_reg - ta_reg;
                    sr_next = sb_reg;
                end
                if (n_next == '0)
                begin
                    d_next  = MW'(1);
                    sr_next = 1'b0;
                end
                ga_next    = n_next;
                gb_next    = d_next;
                pass2_next = 1'b1;
            end
            rau_pkg::S_RN:
            begin
                div_start = 1'b1;
                div_dvd   = n_reg;
                div_dvs   = ga_reg;
            end
            rau_pkg::S_RN_WT:
            begin
                if (div_rsp.done)
                    n_next = div_rsp.quo;
            end
            rau_pkg::S_RD:
            begin
                div_start = 1'b1;
                div_dvd   = d_reg;
                div_dvs   = ga_reg;
            end
            rau_pkg::S_RD_WT:
            begin
                if (div_rsp.done)
                    d_next = div_rsp.quo;
            end
            rau_pkg::S_CHECK:
            begin
                if (d_reg > lim - 1'b1 || (sr_reg ? n_reg > lim : n_reg > lim - 1'b1))
                begin
                    onum_next = '0;
                    oden_next = '0;
                    ost_next  = rau_pkg::ST_OVERFLOW;
                end
                else
                begin
                    onum_next = sr_reg ? (~n_reg[31:0] + 1'b1) : n_reg[31:0];
                    oden_next = d_reg[30:0];
                    ost_next  = rau_pkg::ST_OK;
                end
            end
            rau_pkg::S_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {7'd0, ost_reg, oden_reg, onum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        na_reg   <= na_next;
        da_reg   <= da_next;
        nb_reg   <= nb_next;
        db_reg   <= db_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sr_reg   <= sr_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        prod_reg <= MW'(mul_a) * MW'(mul_b);
        onum_reg <= onum_next;
        oden_reg <= oden_next;
        ost_reg  <= ost_next;
    end

endmodule

// ----- src/rau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// Watches both streams; bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [135:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata
);

    // held result does not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // one item in flight: no input taken while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // after an input transfer the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after input transfer");

    // ok results have a nonzero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[64:63] == rau_pkg::ST_OK |-> m_tdata[62:32] != '0)
        else $error("ok result with zero denominator");

    // error results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[64:63] != rau_pkg::ST_OK |-> m_tdata[62:0] == '0)
        else $error("error result with nonzero fields");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
